FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// No dependencies; define SYNTH to compile the macros away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/u8u16_pkg.sv
// Types, constants and the lead byte classifier of the UTF-8 to UTF-16 decoder.
// No dependencies; used by every module of the block.
package u8u16_pkg;

  localparam int unsigned ADDR_W = 3;

  localparam logic [15:0] REPLACEMENT_UNIT = 16'hfffd;
  localparam logic [20:0] SUPP_BASE        = 21'h10000;
  localparam logic [15:0] HIGH_SURR_BASE   = 16'hd800;
  localparam logic [15:0] LOW_SURR_BASE    = 16'hdc00;
  localparam logic [15:0] CAPACITY_RESET   = 16'hffff;

  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] TWO_LIMIT   = 8'he0;
  localparam logic [7:0] THREE_LIMIT = 8'hf0;

  typedef enum logic [0:0] {
    REG_OUT_CAPACITY = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        string_done;
    logic [15:0] units_written;
    logic        last_in_run;
  } out_item_t;

  typedef struct packed {
    logic       ascii;
    logic [1:0] need;
    logic [4:0] lead_bits;
  } byte_class_t;

  typedef struct packed {
    in_item_t    item;
    byte_class_t cls;
  } front_item_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c.ascii = (b < ASCII_LIMIT);
    if (b < ASCII_LIMIT) begin
      c.need      = 2'd0;
      c.lead_bits = 5'd0;
    end else if (b < TWO_LIMIT) begin
      c.need      = 2'd1;
      c.lead_bits = b[4:0];
    end else if (b < THREE_LIMIT) begin
      c.need      = 2'd2;
      c.lead_bits = {1'b0, b[3:0]};
    end else begin
      c.need      = 2'd3;
      c.lead_bits = {2'b00, b[2:0]};
    end
    return c;
  endfunction

endpackage

FILE: sv/u8u16_front.sv
// Front end: input queue of source bytes, each tagged with its lead class.
// Depends on u8u16_pkg.
module u8u16_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  u8u16_pkg::in_item_t    item,
  output logic                   full,
  input  logic                   pop,
  output u8u16_pkg::front_item_t head,
  output logic                   valid
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8u16_pkg::front_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // classify on the way in so the back end sees the class with the byte
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{item: item, cls: u8u16_pkg::classify(item.in_byte)};
    end
  end

endmodule

FILE: sv/u8u16_res_fifo.sv
// Result queue between the decode engine and the result port.
// Depends on u8u16_pkg.
module u8u16_res_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  u8u16_pkg::out_item_t wr_item,
  output logic                 full,
  input  logic                 rd,
  output u8u16_pkg::out_item_t rd_item,
  output logic                 empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8u16_pkg::out_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

FILE: sv/u8u16_back.sv
// Decode engine: one byte (fresh or replayed) or one low surrogate per cycle while the result queue has room,
// with a staging register that settles the end-of-run flags. Depends on u8u16_pkg.
module u8u16_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [15:0]            cap,
  input  u8u16_pkg::front_item_t head,
  input  logic                   head_valid,
  output logic                   head_pop,
  input  logic                   res_full,
  output logic                   res_push,
  output u8u16_pkg::out_item_t   res_item
);

  // decode state
  logic [4:0]  pp, pp_next;
  logic [1:0]  need, need_next;
  logic [7:0]  held [3];
  logic [1:0]  hc, hc_next;
  logic [15:0] unit_count, unit_count_next;
  logic        stopped, stopped_next;
  // bytes waiting to be decoded again, oldest in the top byte
  logic [23:0] rq, rq_next;
  logic [1:0]  rq_count, rq_count_next;
  logic        step_fin;
  logic        low_pending, low_pending_next;
  logic [15:0] low_unit, low_unit_next;
  // staged result
  u8u16_pkg::out_item_t stage, stage_next;
  logic        stage_valid, stage_valid_next;
  logic        stage_ready, stage_ready_next;

  logic                   active;
  logic                   go;
  logic                   fin;
  logic [7:0]             b;
  u8u16_pkg::byte_class_t cls;
  logic [23:0]            rest;
  logic [1:0]             rem;
  logic                   last;
  logic [7:0]             hw0, hw1, hw2;
  logic [23:0]            heldw_vec;
  logic [1:0]             hcw;
  logic [2:0]             bad;
  logic [1:0]             j;
  logic                   any_bad;
  logic [20:0]            cp;
  logic                   emit;
  logic [20:0]            emit_cp;
  logic [20:0]            supp;
  logic                   brk;
  logic [1:0]             cnt;
  logic [1:0]             start;
  logic                   held_we;
  logic                   unit_valid;
  logic [15:0]            unit_val;
  logic [15:0]            unit_written;
  logic                   step_end;
  logic [23:0]            head_mask;
  u8u16_pkg::out_item_t   new_res;
  u8u16_pkg::out_item_t   close_res;

  // operand selection and continuation check
  always_comb begin
    active   = (rq_count != 2'd0) || low_pending;
    go       = !res_full && (active || head_valid);
    head_pop = go && !active;
    fin      = active ? step_fin : head.item.final_byte;
    b        = (rq_count != 2'd0) ? rq[23:16] : head.item.in_byte;
    cls      = (rq_count != 2'd0) ? u8u16_pkg::classify(rq[23:16]) : head.cls;
    rest     = (rq_count != 2'd0) ? {rq[15:0], 8'h00} : 24'h0;
    rem      = (rq_count != 2'd0) ? rq_count - 2'd1 : 2'd0;
    last     = fin && (rem == 2'd0);

    hw0       = (hc == 2'd0) ? b : held[0];
    hw1       = (hc == 2'd1) ? b : held[1];
    hw2       = (hc == 2'd2) ? b : held[2];
    heldw_vec = {hw0, hw1, hw2};
    hcw       = hc + 2'd1;

    bad[0] = ((hw0 & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG);
    bad[1] = (hcw >= 2'd2) && ((hw1 & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG);
    bad[2] = (hcw == 2'd3) && ((hw2 & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG);
    any_bad = |bad;
    if (bad[0]) begin
      j = 2'd0;
    end else if (bad[1]) begin
      j = 2'd1;
    end else begin
      j = 2'd2;
    end

    case (need)
      2'd1:    cp = {10'b0, pp, hw0[5:0]};
      2'd2:    cp = {5'b0, pp[3:0], hw0[5:0], hw1[5:0]};
      2'd3:    cp = {pp[2:0], hw0[5:0], hw1[5:0], hw2[5:0]};
      default: cp = '0;
    endcase
  end

  // one decode operation
  always_comb begin
    pp_next          = pp;
    need_next        = need;
    hc_next          = hc;
    unit_count_next  = unit_count;
    stopped_next     = stopped;
    rq_next          = rq;
    rq_count_next    = rq_count;
    low_pending_next = low_pending;
    low_unit_next    = low_unit;
    held_we          = 1'b0;
    emit             = 1'b0;
    emit_cp          = '0;
    supp             = '0;
    brk              = 1'b0;
    cnt              = 2'd0;
    start            = 2'd0;
    unit_valid       = 1'b0;
    unit_val         = '0;
    step_end         = 1'b0;
    head_mask        = '0;

    if (low_pending) begin
      unit_valid       = 1'b1;
      unit_val         = low_unit;
      low_pending_next = 1'b0;
      step_end         = (rq_count == 2'd0);
    end else begin
      if (stopped) begin
        // drop the rest of the run while output is stopped
        pp_next   = '0;
        need_next = '0;
        hc_next   = '0;
        brk       = 1'b1;
      end else if (need == 2'd0) begin
        if (unit_count >= cap) begin
          stopped_next = 1'b1;
          brk          = 1'b1;
        end else if (cls.ascii) begin
          emit    = 1'b1;
          emit_cp = {13'b0, b};
        end else if (last) begin
          emit    = 1'b1;
          emit_cp = {5'b0, u8u16_pkg::REPLACEMENT_UNIT};
        end else begin
          pp_next   = cls.lead_bits;
          need_next = cls.need;
          hc_next   = 2'd0;
        end
      end else begin
        held_we = 1'b1;
        if (hcw >= need) begin
          emit = 1'b1;
          if (any_bad) begin
            // bad continuation: replay it and everything after it
            emit_cp = {5'b0, u8u16_pkg::REPLACEMENT_UNIT};
            start   = j;
            cnt     = hcw - j;
          end else begin
            emit_cp = cp;
          end
          pp_next   = '0;
          need_next = '0;
          hc_next   = '0;
        end else if (last) begin
          // cut short at end of string: replay all held bytes
          emit      = 1'b1;
          emit_cp   = {5'b0, u8u16_pkg::REPLACEMENT_UNIT};
          start     = 2'd0;
          cnt       = hcw;
          pp_next   = '0;
          need_next = '0;
          hc_next   = '0;
        end else begin
          hc_next = hcw;
        end
      end

      if (emit) begin
        if (emit_cp >= u8u16_pkg::SUPP_BASE) begin
          supp = emit_cp - u8u16_pkg::SUPP_BASE;
          if (({1'b0, unit_count} + 17'd2) > {1'b0, cap}) begin
            stopped_next = 1'b1;
          end else begin
            unit_valid       = 1'b1;
            unit_val         = u8u16_pkg::HIGH_SURR_BASE + {5'b0, supp[20:10]};
            low_unit_next    = u8u16_pkg::LOW_SURR_BASE + {6'b0, supp[9:0]};
            low_pending_next = 1'b1;
          end
        end else begin
          unit_valid = 1'b1;
          unit_val   = emit_cp[15:0];
        end
      end

      head_mask     = ~(24'hffffff >> {cnt, 3'b000});
      rq_next       = ((heldw_vec << {start, 3'b000}) & head_mask) | (rest >> {cnt, 3'b000});
      rq_count_next = brk ? 2'd0 : cnt + rem;
      step_end      = brk || ((rq_count_next == 2'd0) && !low_pending_next);
    end

    unit_written = unit_count + 16'd1;
    if (unit_valid) begin
      unit_count_next = unit_written;
    end
    if (step_end && fin) begin
      pp_next         = '0;
      need_next       = '0;
      hc_next         = '0;
      unit_count_next = '0;
      stopped_next    = 1'b0;
    end
  end

  // staging: the newest unit waits here until the end of its run is known
  always_comb begin
    new_res = '{code_unit: unit_val, has_unit: 1'b1, string_done: fin && step_end,
                units_written: unit_written, last_in_run: step_end};
    close_res = '{code_unit: 16'h0000, has_unit: 1'b0, string_done: 1'b1,
                  units_written: unit_count, last_in_run: 1'b1};
    stage_next       = stage;
    stage_valid_next = stage_valid;
    stage_ready_next = stage_ready;
    res_push         = 1'b0;
    res_item         = stage;
    if (go) begin
      if (unit_valid) begin
        res_push         = stage_valid;
        stage_next       = new_res;
        stage_valid_next = 1'b1;
        stage_ready_next = step_end;
      end else if (step_end) begin
        if (stage_valid && !stage_ready) begin
          res_push             = 1'b1;
          res_item.last_in_run = 1'b1;
          res_item.string_done = fin;
          stage_valid_next     = 1'b0;
        end else if (stage_valid) begin
          res_push         = 1'b1;
          stage_next       = close_res;
          stage_valid_next = fin;
          stage_ready_next = 1'b1;
        end else if (fin) begin
          res_push = 1'b1;
          res_item = close_res;
        end
      end else if (stage_valid && stage_ready) begin
        res_push         = 1'b1;
        stage_valid_next = 1'b0;
      end
    end else if (stage_valid && stage_ready && !res_full) begin
      res_push         = 1'b1;
      stage_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp          <= '0;
      need        <= '0;
      hc          <= '0;
      unit_count  <= '0;
      stopped     <= 1'b0;
      rq_count    <= '0;
      step_fin    <= 1'b0;
      low_pending <= 1'b0;
      stage_valid <= 1'b0;
      stage_ready <= 1'b0;
    end else begin
      if (go) begin
        pp          <= pp_next;
        need        <= need_next;
        hc          <= hc_next;
        unit_count  <= unit_count_next;
        stopped     <= stopped_next;
        rq_count    <= rq_count_next;
        step_fin    <= fin;
        low_pending <= low_pending_next;
      end
      stage_valid <= stage_valid_next;
      stage_ready <= stage_ready_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rq       <= rq_next;
      low_unit <= low_unit_next;
      if (held_we) begin
        held[hc] <= b;
      end
    end
    stage <= stage_next;
  end

endmodule

FILE: sv/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder: top level with the capacity register.
// Depends on u8u16_pkg, u8u16_front, u8u16_back, u8u16_res_fifo, assert_macros.svh.
//
// Usage:
//   Source bytes enter through a queue port: drive item and raise push; a byte
//   is taken at each edge with push high and full low. Mark the last byte of a
//   string with final_byte. Results leave through a queue port: the oldest
//   result sits on result while empty is low; raise pop to take it.
//   Each byte gives zero to four results; the last one of a byte carries
//   last_in_run, and a string closes with string_done and units_written.
//   out_capacity (APB, byte address 0) limits units per string; write it only
//   while the block is idle.
// Timing:
//   Sustained rate is one byte per cycle while the result queue has room, set by
//   the single decode engine: the low half of a surrogate pair and each byte
//   decoded again after a bad or cut-short sequence take a decode step of their own.
// Reset clears both queues and any pending sequence and sets the capacity to
// 65535. When the receiver stalls, the result queue fills, the decode engine
// holds, and then the input queue fills and raises full.
`include "assert_macros.svh"
module utf8_to_utf16_decoder #(
  parameter int unsigned IN_DEPTH  = 4,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  u8u16_pkg::in_item_t            item,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output u8u16_pkg::out_item_t           result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [u8u16_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [15:0]            out_capacity;
  logic                   cfg_write;
  u8u16_pkg::front_item_t head;
  logic                   head_valid;
  logic                   head_pop;
  logic                   res_full;
  logic                   res_push;
  u8u16_pkg::out_item_t   res_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= u8u16_pkg::CAPACITY_RESET;
    end else if (cfg_write && (paddr[2] == u8u16_pkg::REG_OUT_CAPACITY)) begin
      out_capacity <= pwdata[15:0];
    end
  end

  always_comb begin
    case (u8u16_pkg::reg_index_t'(paddr[2]))
      u8u16_pkg::REG_OUT_CAPACITY: prdata = {16'h0000, out_capacity};
      default:                     prdata = '0;
    endcase
  end

  u8u16_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .pop   (head_pop),
    .head  (head),
    .valid (head_valid)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cap        (out_capacity),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_item   (res_item)
  );

  u8u16_res_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_item (res_item),
    .full    (res_full),
    .rd      (pop),
    .rd_item (result),
    .empty   (empty)
  );

  `ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !full && empty)
  `ASSERT_IMPL(a_pop_has_data, clk, rst, head_pop, head_valid)
  `ASSERT_IMPL(a_no_unit_closes, clk, rst, !empty && !result.has_unit, result.string_done && result.last_in_run && (result.code_unit == 16'h0000))
  `ASSERT_NEXT(a_cap_write, clk, rst, cfg_write && (paddr[2] == u8u16_pkg::REG_OUT_CAPACITY), out_capacity == $past(pwdata[15:0]))

endmodule

FILE: test/utf8_to_utf16_decoder_test.sv
// Self-checking testbench for utf8_to_utf16_decoder: drives source bytes through the
// push/full port, checks every popped UTF-16 word against a built-in decoder model.
// Depends on u8u16_pkg and the decoder RTL.
module utf8_to_utf16_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD      = 10;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int SPARE_REG   = 1;
  localparam int AW          = u8u16_pkg::ADDR_W;
  localparam logic [AW-1:0] CAP_ADDR   = AW'(4 * u8u16_pkg::REG_OUT_CAPACITY);
  localparam logic [AW-1:0] SPARE_ADDR = AW'(4 * SPARE_REG);

  // Expected-word store plus a bytewise decoder that fills it.
  class unit_scoreboard;
    logic [15:0]          capacity;
    logic [20:0]          partial;
    logic [1:0]           need;
    logic [7:0]           held [3];
    int                   held_n;
    logic [15:0]          unit_cnt;
    bit                   stopped;
    logic [15:0]          step_units [$];
    logic [15:0]          step_counts [$];
    u8u16_pkg::out_item_t units_due [$];
    int                   errors;

    function new();
      capacity = u8u16_pkg::CAPACITY_RESET;
      clear_seq();
      unit_cnt = '0;
      stopped  = 1'b0;
      errors   = 0;
    endfunction

    function void clear_seq();
      partial = '0;
      need    = '0;
      held_n  = 0;
    endfunction

    function void push_unit(logic [15:0] u);
      if (step_units.size() >= 4) return;
      unit_cnt = unit_cnt + 16'd1;
      step_units.push_back(u);
      step_counts.push_back(unit_cnt);
    endfunction

    function void emit_point(logic [20:0] cp);
      logic [20:0] off;
      if (cp >= u8u16_pkg::SUPP_BASE) begin
        // a pair that does not fit stops output for the rest of the string
        if ({1'b0, unit_cnt} + 17'd2 > {1'b0, capacity}) begin
          stopped = 1'b1;
          return;
        end
        off = cp - u8u16_pkg::SUPP_BASE;
        push_unit(u8u16_pkg::HIGH_SURR_BASE + 16'(off[20:10]));
        push_unit(u8u16_pkg::LOW_SURR_BASE + 16'(off[9:0]));
      end else begin
        push_unit(cp[15:0]);
      end
    endfunction

    function void note_byte(u8u16_pkg::in_item_t it);
      logic [7:0]           q [$];
      logic [7:0]           b;
      logic [20:0]          cp;
      bit                   fin, last;
      int                   j, start, k, n;
      u8u16_pkg::out_item_t r;
      q = {it.in_byte};
      fin = it.final_byte;
      step_units.delete();
      step_counts.delete();
      while (q.size() > 0) begin
        b = q.pop_front();
        last = fin && (q.size() == 0);
        if (stopped) begin
          clear_seq();
          break;
        end
        if (need == 0) begin
          if (unit_cnt >= capacity) begin
            stopped = 1'b1;
            break;
          end
          if (b < u8u16_pkg::ASCII_LIMIT) begin
            emit_point(21'(b));
            continue;
          end
          if (last) begin
            emit_point(21'(u8u16_pkg::REPLACEMENT_UNIT));
            continue;
          end
          if (b < u8u16_pkg::TWO_LIMIT) begin
            partial = 21'(b[4:0]);
            need = 2'd1;
          end else if (b < u8u16_pkg::THREE_LIMIT) begin
            partial = 21'(b[3:0]);
            need = 2'd2;
          end else begin
            partial = 21'(b[2:0]);
            need = 2'd3;
          end
          held_n = 0;
        end else begin
          start = -1;
          if (held_n < 3) begin
            held[held_n] = b;
            held_n++;
          end
          if (held_n >= need) begin
            cp = partial;
            for (j = 0; j < held_n; j++) begin
              if ((held[j] & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG) break;
              cp = {cp[14:0], held[j][5:0]};
            end
            if (j == held_n) begin
              emit_point(cp);
            end else begin
              emit_point(21'(u8u16_pkg::REPLACEMENT_UNIT));
              start = j;
            end
          end else if (last) begin
            emit_point(21'(u8u16_pkg::REPLACEMENT_UNIT));
            start = 0;
          end
          if (start >= 0 || held_n >= need) begin
            // replay the rejected bytes as fresh leads
            if (start >= 0) begin
              for (j = held_n - 1; j >= start; j--) q.push_front(held[j]);
            end
            clear_seq();
          end
        end
      end

      n = step_units.size();
      for (k = 0; k < n; k++) begin
        r.code_unit     = step_units[k];
        r.has_unit      = 1'b1;
        r.string_done   = fin && (k == n - 1);
        r.units_written = step_counts[k];
        r.last_in_run   = (k == n - 1);
        units_due.push_back(r);
      end
      if (fin) begin
        if (n == 0) begin
          r.code_unit     = '0;
          r.has_unit      = 1'b0;
          r.string_done   = 1'b1;
          r.units_written = unit_cnt;
          r.last_in_run   = 1'b1;
          units_due.push_back(r);
        end
        clear_seq();
        unit_cnt = '0;
        stopped  = 1'b0;
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_unit(u8u16_pkg::out_item_t got);
      u8u16_pkg::out_item_t want;
      if (units_due.size() == 0) begin
        $error("unexpected word: code_unit 0x%0h", got.code_unit);
        errors++;
        return;
      end
      want = units_due.pop_front();
      check_field("code_unit", want.code_unit, got.code_unit);
      check_field("has_unit", 16'(want.has_unit), 16'(got.has_unit));
      check_field("string_done", 16'(want.string_done), 16'(got.string_done));
      check_field("units_written", want.units_written, got.units_written);
      check_field("last_in_run", 16'(want.last_in_run), 16'(got.last_in_run));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  u8u16_pkg::in_item_t  item = '0;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  u8u16_pkg::out_item_t result;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AW-1:0]        paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  unit_scoreboard sb = new();
  int feed_idle_pct  = 0;
  int drain_idle_pct = 0;
  int cycles = 0;

  utf8_to_utf16_decoder i_dut (
    .clk, .rst, .push, .item, .full, .empty, .pop, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("utf8_to_utf16_decoder_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99, 0) >= drain_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_unit(result);
      if (push && !full) sb.note_byte(item);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    u8u16_pkg::in_item_t w;
    w.in_byte    = b;
    w.final_byte = fin;
    while ($urandom_range(99, 0) < feed_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic write_reg(input logic [AW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CAP_ADDR) sb.capacity = data[15:0];
  endtask

  // Stop feeding, wait until every expected word is out, then let in-flight bytes drain.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.units_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One string: mostly well-formed characters, some truncated, broken or raw bytes.
  task automatic send_random_string(inout int sent);
    logic [7:0] text [$];
    logic [7:0] lead;
    int n_chars, kind, ln, n_cont, bad_pos, c, i;
    n_chars = $urandom_range(6, 1);
    for (c = 0; c < n_chars; c++) begin
      kind = $urandom_range(99, 0);
      if (kind < 30) begin
        text.push_back(8'($urandom_range(u8u16_pkg::ASCII_LIMIT - 1, 0)));
      end else if (kind < 94) begin
        ln = $urandom_range(4, 2);
        case (ln)
          2: lead = 8'($urandom_range(u8u16_pkg::TWO_LIMIT - 1, u8u16_pkg::ASCII_LIMIT));
          3: lead = 8'($urandom_range(u8u16_pkg::THREE_LIMIT - 1, u8u16_pkg::TWO_LIMIT));
          default: lead = 8'($urandom_range(8'hff, u8u16_pkg::THREE_LIMIT));
        endcase
        text.push_back(lead);
        n_cont = (kind >= 80 && kind < 88) ? $urandom_range(ln - 2, 0) : ln - 1;
        bad_pos = (kind >= 88) ? $urandom_range(ln - 2, 0) : -1;
        for (i = 0; i < n_cont; i++) begin
          if (i == bad_pos) text.push_back(8'($urandom_range(8'hff, 0) & 8'hbf | 8'h40));
          else text.push_back(u8u16_pkg::CONT_TAG | 8'($urandom_range(63, 0)));
        end
      end else begin
        text.push_back(8'($urandom_range(8'hff, 0)));
      end
    end
    foreach (text[p]) send_byte(text[p], p == text.size() - 1);
    sent += text.size();
  endtask

  task automatic random_phase(input logic [15:0] cap, input int n_bytes);
    int sent;
    sent = 0;
    settle();
    write_reg(CAP_ADDR, 32'(cap));
    while (sent < n_bytes) send_random_string(sent);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    feed_idle_pct  = 32;
    drain_idle_pct = 60;
    send_byte(8'h00, 0); send_byte(8'h7f, 0); send_byte(8'h41, 1);
    send_byte(8'hc3, 0); send_byte(8'ha9, 0);
    send_byte(8'he2, 0); send_byte(8'h82, 0); send_byte(8'hac, 0);
    // four-byte lead gives a surrogate pair
    send_byte(8'hf0, 0); send_byte(8'h9f, 0); send_byte(8'h98, 0); send_byte(8'h80, 0);
    // stray continuation byte acts as a two-byte lead
    send_byte(8'h80, 0); send_byte(8'h80, 0);
    // bad continuation: replacement, then the byte decodes as a lead
    send_byte(8'he2, 0); send_byte(8'h41, 0);
    send_byte(8'hff, 0); send_byte(8'hbf, 0); send_byte(8'hbf, 0); send_byte(8'hbf, 1);
    // string cut short, then a lone lead as the last byte
    send_byte(8'he2, 0); send_byte(8'h82, 1);
    send_byte(8'hc3, 1);

    random_phase(16'd3, 12);
    settle();
    write_reg(SPARE_ADDR, 32'h0000_0001);

    feed_idle_pct  = 60;
    drain_idle_pct = 32;
    random_phase(16'd2, 10);
    random_phase(16'hffff, 16);

    feed_idle_pct  = 0;
    drain_idle_pct = 0;
    random_phase(16'd0, 5);
    random_phase(16'd1, 5);
    random_phase(16'd9, 12);

    settle();
    if (sb.errors == 0) begin
      $display("utf8_to_utf16_decoder_test: done, clean");
    end else begin
      $display("utf8_to_utf16_decoder_test: done, errors");
    end
    $finish;
  end

endmodule
